### rtl/assert_macros.svh
// Assertion helpers for the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/c2d_pkg.sv
package c2d_pkg;

   // Default capacities of the stores.
   localparam int MaxWidthDef  = 64;
   localparam int MaxHeightDef = 64;
   localparam int MaxInChDef   = 8;
   localparam int MaxOutChDef  = 16;
   localparam int MaxKernelDef = 7;

   // Field widths of the request and response.
   localparam int CommandW     = 2;
   localparam int ValueW       = 16;
   localparam int WeightIndexW = 13;
   localparam int PosW         = 6;
   localparam int ChannelW     = 4;
   localparam int StatusW      = 2;

   // Configuration register widths.
   localparam int WidthRegW  = 7;
   localparam int HeightRegW = 7;
   localparam int InChRegW   = 4;
   localparam int OutChRegW  = 5;
   localparam int RadiusRegW = 2;
   localparam int CsrIndexW  = 3;
   localparam int CsrDataW   = 7;

   // Kernel side is odd and follows from the radius register.
   localparam int SideW = RadiusRegW + 1;

   // Signed coordinate width: a 6-bit position shifted by the radius, compared
   // against image sizes of up to 127.
   localparam int CoordW = 12;

   // Q4.12 values.
   localparam int FracBits = 12;

   // Flat weight offset ch * in_channels * side * side.
   localparam int WIdxW = ChannelW + InChRegW + 2 * SideW;

   // Configuration register indexes.
   localparam logic [CsrIndexW-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_IN_CHANNELS   = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_OUT_CHANNELS  = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_KERNEL_RADIUS = 3'd4;
   localparam logic [CsrIndexW-1:0] CSR_BIAS_ENABLE   = 3'd5;

   // Register values after reset.
   localparam logic [WidthRegW-1:0]  WidthReset  = 7'd64;
   localparam logic [HeightRegW-1:0] HeightReset = 7'd64;
   localparam logic [InChRegW-1:0]   InChReset   = 4'd1;
   localparam logic [OutChRegW-1:0]  OutChReset  = 5'd1;
   localparam logic [RadiusRegW-1:0] RadiusReset = 2'd1;
   localparam logic                  BiasReset   = 1'b1;

   // Request commands.
   localparam logic [CommandW-1:0] CMD_LOAD_WEIGHT = 2'd0;
   localparam logic [CommandW-1:0] CMD_LOAD_BIAS   = 2'd1;
   localparam logic [CommandW-1:0] CMD_LOAD_PIXEL  = 2'd2;
   localparam logic [CommandW-1:0] CMD_COMPUTE     = 2'd3;

   // Response status codes.
   localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
   localparam logic [StatusW-1:0] STATUS_SATURATED = 2'd1;
   localparam logic [StatusW-1:0] STATUS_RANGE     = 2'd2;

   typedef struct packed {
      logic [CommandW-1:0]        command;
      logic signed [ValueW-1:0]   value;
      logic [WeightIndexW-1:0]    weight_index;
      logic [PosW-1:0]            pos_x;
      logic [PosW-1:0]            pos_y;
      logic [ChannelW-1:0]        channel;
   } req_type;

   typedef struct packed {
      logic signed [ValueW-1:0] out_value;
      logic [StatusW-1:0]       status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP_A,
      ST_SETUP_B,
      ST_RUN,
      ST_DRAIN,
      ST_SUM,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic capture;
      logic setup_a;
      logic setup_b;
      logic issue;
      logic sum;
      logic load_rsp;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic range_bad;
      logic last_tap;
      logic busy;
   } dp_status_type;

endpackage

### rtl/c2d_datapath.sv
module c2d_datapath #(
   parameter int MAX_WIDTH  = c2d_pkg::MaxWidthDef,
   parameter int MAX_HEIGHT = c2d_pkg::MaxHeightDef,
   parameter int MAX_IN_CH  = c2d_pkg::MaxInChDef,
   parameter int MAX_OUT_CH = c2d_pkg::MaxOutChDef,
   parameter int MAX_KERNEL = c2d_pkg::MaxKernelDef
) (
   input  logic                            clock,
   input  logic                            reset,
   input  c2d_pkg::req_type                req_data,
   input  logic                            csr_we,
   input  logic [c2d_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [c2d_pkg::CsrDataW-1:0]    csr_wdata,
   input  c2d_pkg::ctrl_cmd_type           cmd,
   output c2d_pkg::dp_status_type          dp_status,
   output c2d_pkg::rsp_type                rsp_data
);
   import c2d_pkg::*;

   localparam int MaxRadius = (MAX_KERNEL - 1) / 2;
   localparam int WDepth    = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
   localparam int WAddrW    = (WDepth > 1) ? $clog2(WDepth) : 1;
   localparam int BAddrW    = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
   localparam int XW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CW        = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
   localparam int PAddrW    = CW + YW + XW;
   localparam int PDepth    = 1 << PAddrW;
   localparam int TapCount  = MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
   localparam int AccW      = 2 * ValueW + $clog2(TapCount + 2) + 1;
   localparam int QW        = AccW - FracBits;
   localparam int ChicW     = ChannelW + InChRegW;
   localparam int SqW       = 2 * SideW;

   localparam logic signed [AccW-1:0] RoundHalf = AccW'(2 ** (FracBits - 1));
   localparam logic signed [QW-1:0]   QMax      = QW'(32767);
   localparam logic signed [QW-1:0]   QMin      = QW'(-32768);

   // Configuration registers.
   logic [WidthRegW-1:0]  width_ff;
   logic [HeightRegW-1:0] height_ff;
   logic [InChRegW-1:0]   in_ch_ff;
   logic [OutChRegW-1:0]  out_ch_ff;
   logic [RadiusRegW-1:0] radius_ff;
   logic                  bias_en_ff;

   // Clamped configuration.
   logic [WidthRegW-1:0]  w_cl;
   logic [HeightRegW-1:0] h_cl;
   logic [InChRegW-1:0]   icn_cl;
   logic [OutChRegW-1:0]  ocn_cl;
   logic [RadiusRegW-1:0] r_cl;
   logic [SideW-1:0]      side;
   logic [SideW-1:0]      side_m1;

   // Stores.
   logic signed [ValueW-1:0] weight_mem [WDepth];
   logic signed [ValueW-1:0] bias_mem [MAX_OUT_CH];
   logic signed [ValueW-1:0] pixel_mem [PDepth];

   // Captured compute request and set-up products.
   logic [PosW-1:0]               x_ff;
   logic [PosW-1:0]               y_ff;
   logic [ChannelW-1:0]           ch_ff;
   logic                          range_bad_ff;
   logic [ChicW-1:0]              chic_ff;
   logic [SqW-1:0]                sq_ff;
   logic signed [CoordW-1:0]      x0_ff;
   logic signed [CoordW-1:0]      y0_ff;

   // Tap sequencing.
   logic [SideW-1:0]    kx_ff;
   logic [SideW-1:0]    ky_ff;
   logic [InChRegW-1:0] ic_ff;
   logic [WIdxW-1:0]    waddr_ff;

   logic signed [CoordW-1:0] px;
   logic signed [CoordW-1:0] py;
   logic                     in_image;
   logic [PAddrW-1:0]        paddr;

   // Multiply-accumulate pipeline.
   logic                      v1_ff;
   logic                      in1_ff;
   logic signed [ValueW-1:0]  pix_rd_ff;
   logic signed [ValueW-1:0]  w_rd_ff;
   logic signed [ValueW-1:0]  bias_rd_ff;
   logic signed [ValueW-1:0]  pix_eff;
   logic                      v2_ff;
   logic signed [2*ValueW-1:0] prod_ff;
   logic signed [AccW-1:0]    acc_ff;
   logic signed [AccW-1:0]    sum_ff;
   logic signed [AccW-1:0]    bias_term;
   logic signed [QW-1:0]      q;
   rsp_type                   rsp_ff;

   // Configuration write port.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WidthReset;
         height_ff  <= HeightReset;
         in_ch_ff   <= InChReset;
         out_ch_ff  <= OutChReset;
         radius_ff  <= RadiusReset;
         bias_en_ff <= BiasReset;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff   <= csr_wdata[WidthRegW-1:0];
            CSR_IMAGE_HEIGHT:  height_ff  <= csr_wdata[HeightRegW-1:0];
            CSR_IN_CHANNELS:   in_ch_ff   <= csr_wdata[InChRegW-1:0];
            CSR_OUT_CHANNELS:  out_ch_ff  <= csr_wdata[OutChRegW-1:0];
            CSR_KERNEL_RADIUS: radius_ff  <= csr_wdata[RadiusRegW-1:0];
            CSR_BIAS_ENABLE:   bias_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Clamp each size and radius register to what the stores can hold.
   always_comb begin
      if (width_ff == '0) w_cl = WidthRegW'(1);
      else if (int'(width_ff) > MAX_WIDTH) w_cl = WidthRegW'(MAX_WIDTH);
      else w_cl = width_ff;

      if (height_ff == '0) h_cl = HeightRegW'(1);
      else if (int'(height_ff) > MAX_HEIGHT) h_cl = HeightRegW'(MAX_HEIGHT);
      else h_cl = height_ff;

      if (in_ch_ff == '0) icn_cl = InChRegW'(1);
      else if (int'(in_ch_ff) > MAX_IN_CH) icn_cl = InChRegW'(MAX_IN_CH);
      else icn_cl = in_ch_ff;

      if (out_ch_ff == '0) ocn_cl = OutChRegW'(1);
      else if (int'(out_ch_ff) > MAX_OUT_CH) ocn_cl = OutChRegW'(MAX_OUT_CH);
      else ocn_cl = out_ch_ff;

      if (int'(radius_ff) > MaxRadius) r_cl = RadiusRegW'(MaxRadius);
      else r_cl = radius_ff;

      side    = {r_cl, 1'b1};
      side_m1 = {r_cl, 1'b0};
   end

   // Weight store: loads write at the flat index, taps read sequentially.
   always_ff @(posedge clock) begin
      if (cmd.load && req_data.command == CMD_LOAD_WEIGHT &&
          int'(req_data.weight_index) < WDepth) begin
         weight_mem[WAddrW'(req_data.weight_index)] <= req_data.value;
      end
      w_rd_ff <= weight_mem[WAddrW'(waddr_ff)];
   end

   // Bias store: read continuously at the captured output channel.
   always_ff @(posedge clock) begin
      if (cmd.load && req_data.command == CMD_LOAD_BIAS &&
          int'(req_data.channel) < MAX_OUT_CH) begin
         bias_mem[BAddrW'(req_data.channel)] <= req_data.value;
      end
      bias_rd_ff <= bias_mem[BAddrW'(ch_ff)];
   end

   // Pixel store, addressed as channel, row, column bit fields.
   always_ff @(posedge clock) begin
      if (cmd.load && req_data.command == CMD_LOAD_PIXEL &&
          int'(req_data.pos_x) < MAX_WIDTH && int'(req_data.pos_y) < MAX_HEIGHT &&
          int'(req_data.channel) < MAX_IN_CH) begin
         pixel_mem[{CW'(req_data.channel), YW'(req_data.pos_y), XW'(req_data.pos_x)}]
            <= req_data.value;
      end
      pix_rd_ff <= pixel_mem[paddr];
   end

   // Current tap position and whether it lies inside the image.
   always_comb begin
      px       = x0_ff + $signed(CoordW'(kx_ff));
      py       = y0_ff + $signed(CoordW'(ky_ff));
      in_image = (px >= 0) && (px < $signed(CoordW'(w_cl))) &&
                 (py >= 0) && (py < $signed(CoordW'(h_cl)));
      paddr    = {CW'(ic_ff), YW'(py), XW'(px)};
   end

   // Request capture and set-up of the tap walk.
   always_ff @(posedge clock) begin
      if (reset) begin
         range_bad_ff <= 1'b0;
      end else if (cmd.capture) begin
         range_bad_ff <= ({1'b0, req_data.pos_x} >= w_cl) ||
                         ({1'b0, req_data.pos_y} >= h_cl) ||
                         ({1'b0, req_data.channel} >= ocn_cl);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff  <= req_data.pos_x;
         y_ff  <= req_data.pos_y;
         ch_ff <= req_data.channel;
      end
      if (cmd.setup_a) begin
         chic_ff <= ChicW'(ch_ff) * ChicW'(icn_cl);
         sq_ff   <= SqW'(side) * SqW'(side);
         x0_ff   <= $signed(CoordW'(x_ff)) - $signed(CoordW'(r_cl));
         y0_ff   <= $signed(CoordW'(y_ff)) - $signed(CoordW'(r_cl));
      end
   end

   // Tap counters run column, row, then input channel, as the flat weight
   // index does, so the weight address simply counts up.
   always_ff @(posedge clock) begin
      if (cmd.setup_b) begin
         waddr_ff <= WIdxW'(chic_ff) * WIdxW'(sq_ff);
         kx_ff    <= '0;
         ky_ff    <= '0;
         ic_ff    <= '0;
      end else if (cmd.issue) begin
         waddr_ff <= waddr_ff + WIdxW'(1);
         if (kx_ff == side_m1) begin
            kx_ff <= '0;
            if (ky_ff == side_m1) begin
               ky_ff <= '0;
               ic_ff <= ic_ff + InChRegW'(1);
            end else begin
               ky_ff <= ky_ff + SideW'(1);
            end
         end else begin
            kx_ff <= kx_ff + SideW'(1);
         end
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
      end
   end

   // Multiply, then accumulate; padding pixels read as zero.
   assign pix_eff = in1_ff ? pix_rd_ff : '0;

   always_ff @(posedge clock) begin
      in1_ff  <= in_image;
      prod_ff <= pix_eff * w_rd_ff;
      if (cmd.setup_b) acc_ff <= '0;
      else if (v2_ff) acc_ff <= acc_ff + AccW'(prod_ff);
   end

   // Add bias if enabled, round, then saturate or flag a range error.
   always_comb begin
      bias_term = bias_en_ff ? (AccW'(bias_rd_ff) <<< FracBits) : '0;
      q         = $signed(sum_ff[AccW-1:FracBits]);
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) sum_ff <= acc_ff + bias_term + RoundHalf;
      if (cmd.load_rsp) begin
         if (range_bad_ff) begin
            rsp_ff.out_value <= '0;
            rsp_ff.status    <= STATUS_RANGE;
         end else if (q > QMax) begin
            rsp_ff.out_value <= ValueW'(QMax);
            rsp_ff.status    <= STATUS_SATURATED;
         end else if (q < QMin) begin
            rsp_ff.out_value <= ValueW'(QMin);
            rsp_ff.status    <= STATUS_SATURATED;
         end else begin
            rsp_ff.out_value <= ValueW'(q);
            rsp_ff.status    <= STATUS_OK;
         end
      end
   end

   assign rsp_data = rsp_ff;

   assign dp_status.range_bad = range_bad_ff;
   assign dp_status.last_tap  = (kx_ff == side_m1) && (ky_ff == side_m1) &&
                                (ic_ff == icn_cl - InChRegW'(1));
   assign dp_status.busy      = v1_ff | v2_ff;

endmodule

### rtl/c2d_control.sv
`include "assert_macros.svh"

module c2d_control (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [c2d_pkg::CommandW-1:0]    req_command,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output c2d_pkg::ctrl_cmd_type           cmd,
   input  c2d_pkg::dp_status_type          dp_status
);
   import c2d_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // State and response valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == CMD_COMPUTE) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_SETUP_A;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_SETUP_A: begin
            cmd.setup_a = 1'b1;
            if (dp_status.range_bad) state_in = ST_RESP;
            else state_in = ST_SETUP_B;
         end
         ST_SETUP_B: begin
            cmd.setup_b = 1'b1;
            state_in    = ST_RUN;
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (dp_status.last_tap) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!dp_status.busy) state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The response register holds its result until the consumer takes it.
   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   `ASSERT_NEVER(a_no_overwrite, clock, reset, cmd.load_rsp && rsp_valid_ff && !rsp_ready, "pending response overwritten")
   `ASSERT_IMPLY(a_issue_in_range, clock, reset, cmd.issue, !dp_status.range_bad, "taps issued for a rejected position")
   `ASSERT_IMPLY(a_sum_after_drain, clock, reset, state_ff == ST_SUM, !dp_status.busy, "sum taken before the pipeline drained")
   `ASSERT_IMPLY(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_RESP), "response raised outside the response state")

endmodule

### rtl/conv2d_same_padding_unit.sv
// Channel   Direction  Handshake                  Payload
// req       in         req_valid / req_ready      req_data (c2d_pkg::req_type)
// rsp       out        rsp_valid / rsp_ready      rsp_data (c2d_pkg::rsp_type)
// csr       in         csr_we, write only         csr_index, csr_wdata
//
// Load requests are taken back to back while idle and give no response.
// A compute request walks in_channels * side * side taps, one
// multiply-accumulate per cycle through the shared multiplier; a
// position or channel outside the configured range skips the walk.
// Reset is synchronous; the stores hold no defined contents until loaded.
// A stalled response is held in its register while further loads are taken.
module conv2d_same_padding_unit #(
   parameter int MAX_WIDTH  = c2d_pkg::MaxWidthDef,
   parameter int MAX_HEIGHT = c2d_pkg::MaxHeightDef,
   parameter int MAX_IN_CH  = c2d_pkg::MaxInChDef,
   parameter int MAX_OUT_CH = c2d_pkg::MaxOutChDef,
   parameter int MAX_KERNEL = c2d_pkg::MaxKernelDef
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  c2d_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output c2d_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [c2d_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [c2d_pkg::CsrDataW-1:0]    csr_wdata
);
   import c2d_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // Sequencer for loads, tap walk and response.
   c2d_control u_control (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_data.command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd),
      .dp_status   (dp_status)
   );

   // Stores, configuration and multiply-accumulate datapath.
   c2d_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_IN_CH  (MAX_IN_CH),
      .MAX_OUT_CH (MAX_OUT_CH),
      .MAX_KERNEL (MAX_KERNEL)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp_data  (rsp_data)
   );

endmodule
